>>> hdl/pgf_pkg.sv
`default_nettype none
package pgf_pkg;

  localparam int PGF_DIMENSIONS = 3;
  localparam int AXES           = 3;

  localparam int COORD_W = 32;
  localparam int MASS_W  = 32;
  localparam int GRAV_W  = 32;
  localparam int FORCE_W = 48;
  localparam int LIMB_W  = 32;

  // |p2 - p1| needs one bit more than a coordinate
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W - 1;   // square of a magnitude <= 2^32
  localparam int SUM_W   = SQ_W + 1;        // sum of up to three squares
  localparam int SCALE_W = 32;              // Q16.16 squared back to Q16.16
  localparam int ROOT_W  = (SUM_W + SCALE_W) / 2;
  localparam int K1_W    = GRAV_W + MASS_W;
  localparam int K2_W    = K1_W + MASS_W;
  localparam int PROD_W  = K2_W + MAG_W;
  localparam int NUM_W   = PROD_W + SCALE_W;
  localparam int DEN_W   = SUM_W + ROOT_W;
  localparam int QUOT_W  = FORCE_W;
  localparam int DIV_LAT = QUOT_W + 1;

  localparam logic [FORCE_W-1:0] POS_LIM = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

  // fields that ride alongside the square root
  typedef struct packed {
    logic [SUM_W-1:0]            sum;
    logic [K2_W-1:0]             k2;
    logic [AXES-1:0][MAG_W-1:0]  mag;
    logic [AXES-1:0]             neg;
  } pgf_carry_t;

  // fields that ride alongside the dividers
  typedef struct packed {
    logic [AXES-1:0] neg;
    logic            zero;
  } pgf_flags_t;

endpackage
`default_nettype wire

>>> hdl/pgf_sqrt.sv
`default_nettype none
module pgf_sqrt
  import pgf_pkg::*;
#(
  parameter int ROOT_BITS = ROOT_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [2*ROOT_BITS-1:0]   in_radicand,
  output logic                          out_valid,
  output logic [ROOT_BITS-1:0]          out_root
);

  localparam int RAD_W = 2 * ROOT_BITS;

  logic [RAD_W-1:0] rem_r [ROOT_BITS];
  logic [RAD_W-1:0] res_r [ROOT_BITS];
  logic             vld_r [ROOT_BITS];

  // one root bit per stage, restoring form
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BITC = RAD_W'(1) << (2 * (ROOT_BITS - 1 - k));
    logic [RAD_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;
    logic             vld_in;

    if (k == 0) begin : g_first
      assign rem_in = in_radicand;
      assign res_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    assign trial = res_in + BITC;

    always_comb begin
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BITC;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign out_valid = vld_r[ROOT_BITS-1];
  assign out_root  = res_r[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule
`default_nettype wire

>>> hdl/pgf_div.sv
`default_nettype none
module pgf_div
  import pgf_pkg::*;
#(
  parameter int NUM_BITS  = NUM_W,
  parameter int DEN_BITS  = DEN_W,
  parameter int QUOT_BITS = QUOT_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [NUM_BITS-1:0]    in_num,
  input  wire logic [DEN_BITS-1:0]    in_den,
  output logic                        out_valid,
  output logic [QUOT_BITS-1:0]        out_quot,
  output logic                        out_big
);

  localparam int REM_W = ((NUM_BITS > DEN_BITS + QUOT_BITS) ?
                          NUM_BITS : DEN_BITS + QUOT_BITS) + 1;

  logic [REM_W-1:0]     rem_r  [QUOT_BITS+1];
  logic [DEN_BITS-1:0]  den_r  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quot_r [QUOT_BITS+1];
  logic                 big_r  [QUOT_BITS+1];
  logic                 vld_r  [QUOT_BITS+1];

  // head stage: quotient that would not fit in QUOT_BITS is flagged here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0]  <= REM_W'(in_num);
    den_r[0]  <= in_den;
    quot_r[0] <= '0;
    big_r[0]  <= REM_W'(in_num) >= (REM_W'(in_den) << QUOT_BITS);
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    localparam int SH = QUOT_BITS - 1 - k;
    logic [REM_W-1:0] dsh, rem_nxt;
    logic             take;

    assign dsh  = REM_W'(den_r[k]) << SH;
    assign take = rem_r[k] >= dsh;

    always_comb begin
      rem_nxt = take ? (rem_r[k] - dsh) : rem_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1]  <= rem_nxt;
      den_r[k+1]  <= den_r[k];
      quot_r[k+1] <= {quot_r[k][QUOT_BITS-2:0], take};
      big_r[k+1]  <= big_r[k];
    end
  end

  assign out_valid = vld_r[QUOT_BITS];
  assign out_quot  = quot_r[QUOT_BITS];
  assign out_big   = big_r[QUOT_BITS];

endmodule
`default_nettype wire

>>> hdl/pairwise_gravity_force.sv
// Pairwise gravity force: one body pair per beat, fully pipelined.
// Throughput: one beat per clock, busy is never raised.
// Each beat passes stages 1 to 3, the bit-per-stage square root, M1, M2,
// the bit-per-stage dividers and the output stage, in that order.
// Reset (rst_n, synchronous, active low) clears all valid bits and G to zero.
// The receiver cannot stall: each result shows on out_* for one cycle with out_valid.
`default_nettype none
module pairwise_gravity_force
  import pgf_pkg::*;
#(
  parameter int DIMENSIONS = PGF_DIMENSIONS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [GRAV_W-1:0]          cfg_wdata,
  // command side
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [COORD_W-1:0]  in_body1_x,
  input  wire logic signed [COORD_W-1:0]  in_body1_y,
  input  wire logic signed [COORD_W-1:0]  in_body1_z,
  input  wire logic signed [COORD_W-1:0]  in_body2_x,
  input  wire logic signed [COORD_W-1:0]  in_body2_y,
  input  wire logic signed [COORD_W-1:0]  in_body2_z,
  input  wire logic [MASS_W-1:0]          in_body1_mass,
  input  wire logic [MASS_W-1:0]          in_body2_mass,
  // result side
  output logic                            out_valid,
  output logic signed [FORCE_W-1:0]       out_force_x,
  output logic signed [FORCE_W-1:0]       out_force_y,
  output logic signed [FORCE_W-1:0]       out_force_z,
  output logic                            out_coincident,
  output logic                            out_saturated
);

  // nothing ever holds the input off
  assign busy = 1'b0;

  // gravitational constant, Q0.32
  logic [GRAV_W-1:0] grav_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= '0;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: separation magnitudes and signs, G*m1
  // ---------------------------------------------------------------------
  logic [COORD_W-1:0] p1 [AXES];
  logic [COORD_W-1:0] p2 [AXES];
  assign p1[0] = in_body1_x;
  assign p1[1] = in_body1_y;
  assign p1[2] = in_body1_z;
  assign p2[0] = in_body2_x;
  assign p2[1] = in_body2_y;
  assign p2[2] = in_body2_z;

  logic [AXES-1:0][MAG_W-1:0] mag_nxt;
  logic [AXES-1:0]            neg_nxt;

  always_comb begin
    logic [MAG_W-1:0] d;
    for (int i = 0; i < AXES; i++) begin
      d = {p2[i][COORD_W-1], p2[i]} - {p1[i][COORD_W-1], p1[i]};
      if (i < DIMENSIONS) begin
        neg_nxt[i] = d[MAG_W-1];
        mag_nxt[i] = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
      end else begin
        // axis not in use: no part in the distance, force stays zero
        neg_nxt[i] = 1'b0;
        mag_nxt[i] = '0;
      end
    end
  end

  logic                       v1_r;
  logic [AXES-1:0][MAG_W-1:0] mag1_r;
  logic [AXES-1:0]            neg1_r;
  logic [K1_W-1:0]            k1_r;
  logic [MASS_W-1:0]          m2_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    mag1_r <= mag_nxt;
    neg1_r <= neg_nxt;
    k1_r   <= {{MASS_W{1'b0}}, grav_r} * {{GRAV_W{1'b0}}, in_body1_mass};
    m2_1_r <= in_body2_mass;
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares, partial products of G*m1*m2
  // ---------------------------------------------------------------------
  logic                       v2_r;
  logic [AXES-1:0][SQ_W-1:0]  sq2_r;
  logic [AXES-1:0][MAG_W-1:0] mag2_r;
  logic [AXES-1:0]            neg2_r;
  logic [2*LIMB_W-1:0]        kp0_r, kp1_r;

  always_ff @(posedge clk) begin
    logic [2*MAG_W-1:0] sqw;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int i = 0; i < AXES; i++) begin
      sqw      = {{MAG_W{1'b0}}, mag1_r[i]} * {{MAG_W{1'b0}}, mag1_r[i]};
      sq2_r[i] <= sqw[SQ_W-1:0];
    end
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    kp0_r  <= {{LIMB_W{1'b0}}, k1_r[LIMB_W-1:0]}      * {{LIMB_W{1'b0}}, m2_1_r};
    kp1_r  <= {{LIMB_W{1'b0}}, k1_r[2*LIMB_W-1:LIMB_W]} * {{LIMB_W{1'b0}}, m2_1_r};
  end

  // ---------------------------------------------------------------------
  // Stage 3: squared distance and G*m1*m2
  // ---------------------------------------------------------------------
  logic       v3_r;
  pgf_carry_t c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    c3_r.sum <= SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
    c3_r.k2  <= K2_W'(kp0_r) + (K2_W'(kp1_r) << LIMB_W);
    c3_r.mag <= mag2_r;
    c3_r.neg <= neg2_r;
  end

  // ---------------------------------------------------------------------
  // Square root of S * 2^32, one bit per stage; operands ride a delay line
  // ---------------------------------------------------------------------
  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;

  pgf_sqrt #(.ROOT_BITS(ROOT_W)) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v3_r),
    .in_radicand({c3_r.sum, {SCALE_W{1'b0}}}),
    .out_valid  (rt_valid),
    .out_root   (rt_root)
  );

  pgf_carry_t dl_r [ROOT_W];
  always_ff @(posedge clk) begin
    dl_r[0] <= c3_r;
    for (int k = 1; k < ROOT_W; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  pgf_carry_t cs;
  assign cs = dl_r[ROOT_W-1];

  // ---------------------------------------------------------------------
  // M1: partial products of S*R and of K*|d_i|, 32-bit limbs
  // ---------------------------------------------------------------------
  localparam int S_LIMBS = (SUM_W + LIMB_W - 1) / LIMB_W;
  localparam int R_LIMBS = (ROOT_W + LIMB_W - 1) / LIMB_W;
  localparam int K_LIMBS = (K2_W + LIMB_W - 1) / LIMB_W;

  logic [S_LIMBS*LIMB_W-1:0] s_pad;
  logic [R_LIMBS*LIMB_W-1:0] r_pad;
  logic [K_LIMBS*LIMB_W-1:0] k_pad;
  assign s_pad = (S_LIMBS*LIMB_W)'(cs.sum);
  assign r_pad = (R_LIMBS*LIMB_W)'(rt_root);
  assign k_pad = (K_LIMBS*LIMB_W)'(cs.k2);

  logic                      vm1_r;
  logic [2*LIMB_W-1:0]       dpp_r [S_LIMBS][R_LIMBS];
  logic [LIMB_W+MAG_W-1:0]   npp_r [AXES][K_LIMBS];
  pgf_flags_t                fm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else begin
      vm1_r <= rt_valid;
    end
    for (int a = 0; a < S_LIMBS; a++) begin
      for (int b = 0; b < R_LIMBS; b++) begin
        dpp_r[a][b] <= {{LIMB_W{1'b0}}, s_pad[a*LIMB_W +: LIMB_W]}
                     * {{LIMB_W{1'b0}}, r_pad[b*LIMB_W +: LIMB_W]};
      end
    end
    for (int i = 0; i < AXES; i++) begin
      for (int a = 0; a < K_LIMBS; a++) begin
        npp_r[i][a] <= {{MAG_W{1'b0}}, k_pad[a*LIMB_W +: LIMB_W]}
                     * {{LIMB_W{1'b0}}, cs.mag[i]};
      end
    end
    fm1_r.neg  <= cs.neg;
    fm1_r.zero <= (cs.sum == '0);
  end

  // ---------------------------------------------------------------------
  // M2: sum the partial products
  // ---------------------------------------------------------------------
  logic [DEN_W-1:0]  den_nxt;
  logic [PROD_W-1:0] num_nxt [AXES];

  always_comb begin
    den_nxt = '0;
    for (int a = 0; a < S_LIMBS; a++) begin
      for (int b = 0; b < R_LIMBS; b++) begin
        den_nxt = den_nxt + (DEN_W'(dpp_r[a][b]) << (LIMB_W * (a + b)));
      end
    end
    for (int i = 0; i < AXES; i++) begin
      num_nxt[i] = '0;
      for (int a = 0; a < K_LIMBS; a++) begin
        num_nxt[i] = num_nxt[i] + (PROD_W'(npp_r[i][a]) << (LIMB_W * a));
      end
    end
  end

  logic              vm2_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] num_r [AXES];
  pgf_flags_t        fm2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else begin
      vm2_r <= vm1_r;
    end
    den_r <= den_nxt;
    for (int i = 0; i < AXES; i++) begin
      num_r[i] <= num_nxt[i];
    end
    fm2_r <= fm1_r;
  end

  // ---------------------------------------------------------------------
  // Dividers: q_i = K*|d_i|*2^32 / (S*R), one quotient bit per stage
  // ---------------------------------------------------------------------
  logic [AXES-1:0]   dv_valid;
  logic [QUOT_W-1:0] quot [AXES];
  logic [AXES-1:0]   big;

  for (genvar i = 0; i < AXES; i++) begin : g_div
    pgf_div #(
      .NUM_BITS (NUM_W),
      .DEN_BITS (DEN_W),
      .QUOT_BITS(QUOT_W)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vm2_r),
      .in_num   ({num_r[i], {SCALE_W{1'b0}}}),
      .in_den   (den_r),
      .out_valid(dv_valid[i]),
      .out_quot (quot[i]),
      .out_big  (big[i])
    );
  end

  pgf_flags_t fl_r [DIV_LAT];
  always_ff @(posedge clk) begin
    fl_r[0] <= fm2_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      fl_r[k] <= fl_r[k-1];
    end
  end

  pgf_flags_t fd;
  assign fd = fl_r[DIV_LAT-1];

  // ---------------------------------------------------------------------
  // Output stage: sign, clip, coincident override
  // ---------------------------------------------------------------------
  logic [FORCE_W-1:0] force_nxt [AXES];
  logic               sat_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (fd.zero) begin
        force_nxt[i] = '0;
      end else if (fd.neg[i]) begin
        if (big[i] || (quot[i] > NEG_LIM)) begin
          force_nxt[i] = NEG_LIM;
          sat_nxt      = 1'b1;
        end else begin
          force_nxt[i] = ~quot[i] + FORCE_W'(1);
        end
      end else begin
        if (big[i] || (quot[i] > POS_LIM)) begin
          force_nxt[i] = POS_LIM;
          sat_nxt      = 1'b1;
        end else begin
          force_nxt[i] = quot[i];
        end
      end
    end
  end

  logic               out_valid_r;
  logic [FORCE_W-1:0] fx_r, fy_r, fz_r;
  logic               coin_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid[0];
    end
    fx_r   <= force_nxt[0];
    fy_r   <= force_nxt[1];
    fz_r   <= force_nxt[2];
    coin_r <= fd.zero;
    sat_r  <= sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_force_x    = fx_r;
  assign out_force_y    = fy_r;
  assign out_force_z    = fz_r;
  assign out_coincident = coin_r;
  assign out_saturated  = sat_r;

endmodule
`default_nettype wire
